@@ rtl/core/spra_pkg.sv @@
// shared types and constants of the spi register access master
package spra_pkg;

   localparam int OPCODE_W = 2;
   localparam int ADDR_W   = 6;
   localparam int DATA_W   = 8;
   localparam int FRAME_W  = 16;
   localparam int COUNT_W  = 4;

   localparam logic [OPCODE_W-1:0] OP_TICK  = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_WRITE = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_READ  = 2'd2;

   localparam logic [ADDR_W-1:0]  ADDR_MASK  = 6'h3f;
   localparam logic [DATA_W-1:0]  WRITE_FLAG = 8'h80;
   localparam logic [COUNT_W-1:0] LAST_BIT   = 4'd15;

   typedef struct packed {
      logic [OPCODE_W-1:0] opcode;
      logic [ADDR_W-1:0]   reg_addr;
      logic [DATA_W-1:0]   write_data;
      logic                miso;
   } req_type;

   typedef struct packed {
      logic              chip_select_n;
      logic              mosi;
      logic              clock_pulse;
      logic              busy_res;
      logic              done_res;
      logic [DATA_W-1:0] read_byte;
   } rsp_type;

endpackage

@@ rtl/core/spra_req_if.sv @@
// request channel interface of the spi register access master
interface spra_req_if import spra_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [OPCODE_W-1:0] opcode;
   logic [ADDR_W-1:0]   reg_addr;
   logic [DATA_W-1:0]   write_data;
   logic                miso;

   modport source (output valid, output opcode, output reg_addr, output write_data,
                   output miso, input ready);
   modport sink (input valid, input opcode, input reg_addr, input write_data,
                 input miso, output ready);
endinterface

@@ rtl/core/spra_rsp_if.sv @@
// response channel interface of the spi register access master
interface spra_rsp_if import spra_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              chip_select_n;
   logic              mosi;
   logic              clock_pulse;
   logic              busy_res;
   logic              done_res;
   logic [DATA_W-1:0] read_byte;

   modport source (output valid, output chip_select_n, output mosi, output clock_pulse,
                   output busy_res, output done_res, output read_byte, input ready);
   modport sink (input valid, input chip_select_n, input mosi, input clock_pulse,
                 input busy_res, input done_res, input read_byte, output ready);
endinterface

@@ rtl/core/spra_engine.sv @@
// access state and per-bit-period logic of the spi register access master
module spra_engine import spra_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    accept,
   input  req_type req_data,
   output rsp_type rsp_data
);

   logic               active_ff,  active_in;
   logic               is_read_ff, is_read_in;
   logic [COUNT_W-1:0] count_ff,   count_in;
   logic [FRAME_W-1:0] tx_ff,      tx_in;
   logic [DATA_W-1:0]  rx_ff,      rx_in;

   logic               start;
   logic [DATA_W-1:0]  cmd;
   logic               cur_active;
   logic               cur_read;
   logic [COUNT_W-1:0] cur_count;
   logic [FRAME_W-1:0] cur_tx;
   logic [DATA_W-1:0]  cur_rx;
   logic               last;

   always_comb begin
      start = !active_ff && (req_data.opcode == OP_WRITE || req_data.opcode == OP_READ);
      cmd   = {1'b0, req_data.reg_addr & ADDR_MASK, 1'b0};
      if (req_data.opcode == OP_WRITE) begin
         cmd = cmd | WRITE_FLAG;
      end

      // a start loads the frame and is itself the first bit period
      cur_active = active_ff || start;
      cur_read   = start ? (req_data.opcode == OP_READ) : is_read_ff;
      cur_count  = start ? '0 : count_ff;
      cur_rx     = start ? '0 : rx_ff;
      if (start) begin
         cur_tx = (req_data.opcode == OP_WRITE) ? {cmd, req_data.write_data}
                                                : {cmd, {DATA_W{1'b0}}};
      end else begin
         cur_tx = tx_ff;
      end

      last       = (cur_count == LAST_BIT);
      active_in  = active_ff;
      is_read_in = is_read_ff;
      count_in   = count_ff;
      tx_in      = tx_ff;
      rx_in      = rx_ff;
      rsp_data   = '{chip_select_n: 1'b1, mosi: 1'b0, clock_pulse: 1'b0, busy_res: 1'b0,
                     done_res: 1'b0, read_byte: '0};

      if (cur_active) begin
         tx_in      = {cur_tx[FRAME_W-2:0], 1'b0};
         is_read_in = cur_read;
         // data half of a read shifts miso in
         rx_in      = (cur_read && cur_count[COUNT_W-1]) ? {cur_rx[DATA_W-2:0], req_data.miso}
                                                         : cur_rx;
         active_in  = !last;
         count_in   = last ? '0 : cur_count + 1'b1;
         rsp_data.chip_select_n = 1'b0;
         rsp_data.mosi          = cur_tx[FRAME_W-1];
         rsp_data.clock_pulse   = 1'b1;
         rsp_data.busy_res      = 1'b1;
         rsp_data.done_res      = last;
         rsp_data.read_byte     = (last && cur_read) ? rx_in : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         count_ff  <= '0;
      end else if (accept) begin
         active_ff <= active_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         is_read_ff <= is_read_in;
         tx_ff      <= tx_in;
         rx_ff      <= rx_in;
      end
   end

`ifndef SYNTH
   a_idle_count_zero: assert property (@(posedge clock) disable iff (reset)
      !active_ff |-> count_ff == '0)
      else $error("bit counter not cleared while idle");

   a_done_in_access: assert property (@(posedge clock) disable iff (reset)
      accept && rsp_data.done_res |-> rsp_data.busy_res && !rsp_data.chip_select_n)
      else $error("done outside an access");

   a_release_after_last: assert property (@(posedge clock) disable iff (reset)
      accept && active_ff && count_ff == LAST_BIT |=> !active_ff)
      else $error("access not released after last bit");

   a_stay_active: assert property (@(posedge clock) disable iff (reset)
      accept && active_ff && count_ff != LAST_BIT |=> active_ff && count_ff != '0)
      else $error("access ended early");
`endif

endmodule

@@ rtl/core/spi_register_access_master.sv @@
// top level of the spi register access master
//
// each request on req is one sck bit period. opcode write or read while idle
// starts a sixteen-period access: command byte (address shifted left by one,
// bit 7 set on a write) then the data byte, msb first, chip select low
// throughout. a read drives mosi low and shifts miso in over the last eight
// periods. any request while busy, or a tick or the unused opcode while idle, is a plain period.
// every request yields exactly one response on rsp carrying chip select,
// mosi, clock pulse, busy, done and the read byte for that period.
// the response is registered: it sits in the output register the cycle
// after its request is accepted.
// throughput: one request per cycle while the receiver does not stall; the per-period logic is a single pass
// between the access state registers and the output register.
// a stalled receiver holds the output register; req.ready stays high as long
// as the register is empty or is being drained in the same cycle.
// reset (synchronous, active high) empties the output register and returns
// the access state to idle.
module spi_register_access_master import spra_pkg::*; (
   input logic       clock,
   input logic       reset,
   spra_req_if.sink  req,
   spra_rsp_if.source rsp
);

   logic    accept;
   req_type req_data;
   rsp_type step_rsp;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff,  rsp_data_in;

   // take a request whenever the output register is free this cycle
   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign accept    = req.valid && req.ready;

   assign req_data = '{opcode: req.opcode, reg_addr: req.reg_addr,
                       write_data: req.write_data, miso: req.miso};

   spra_engine u_engine (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_data (req_data),
      .rsp_data (step_rsp)
   );

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = step_rsp;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.chip_select_n = rsp_data_ff.chip_select_n;
   assign rsp.mosi          = rsp_data_ff.mosi;
   assign rsp.clock_pulse   = rsp_data_ff.clock_pulse;
   assign rsp.busy_res      = rsp_data_ff.busy_res;
   assign rsp.done_res      = rsp_data_ff.done_res;
   assign rsp.read_byte     = rsp_data_ff.read_byte;

endmodule

@@ tb/tb_spi_register_access_master.sv @@
// testbench for the spi register access master: bit-period stimulus, scoreboard check
`timescale 1ns / 1ps

import spra_pkg::*;

// tracks the access state of the master and holds the expected per-period responses
class spi_access_scoreboard;
   bit                 in_access;
   bit                 reading;
   bit [COUNT_W-1:0]   period_idx;
   bit [FRAME_W-1:0]   out_frame;
   bit [DATA_W-1:0]    in_byte;
   rsp_type            pending[$];
   int unsigned        fail_count;

   function new();
      in_access  = 1'b0;
      reading    = 1'b0;
      period_idx = '0;
      out_frame  = '0;
      in_byte    = '0;
      fail_count = 0;
   endfunction

   // one accepted request is one sck period and yields exactly one response
   function void note_request(req_type r);
      rsp_type           want;
      bit [DATA_W-1:0]   cmd;
      want = '0;
      want.chip_select_n = 1'b1;
      if (!in_access && (r.opcode == OP_WRITE || r.opcode == OP_READ)) begin
         cmd = {1'b0, r.reg_addr & ADDR_MASK, 1'b0};
         if (r.opcode == OP_WRITE) begin
            cmd       = cmd | WRITE_FLAG;
            out_frame = {cmd, r.write_data};
            reading   = 1'b0;
         end else begin
            out_frame = {cmd, {DATA_W{1'b0}}};
            reading   = 1'b1;
         end
         period_idx = '0;
         in_byte    = '0;
         in_access  = 1'b1;
      end
      if (in_access) begin
         want.chip_select_n = 1'b0;
         want.clock_pulse   = 1'b1;
         want.busy_res      = 1'b1;
         want.mosi          = out_frame[FRAME_W-1];
         out_frame          = out_frame << 1;
         if (reading && period_idx >= DATA_W)
            in_byte = {in_byte[DATA_W-2:0], r.miso};
         if (period_idx == LAST_BIT) begin
            want.done_res  = 1'b1;
            want.read_byte = reading ? in_byte : '0;
            in_access      = 1'b0;
            period_idx     = '0;
         end else begin
            period_idx = period_idx + 1'b1;
         end
      end
      pending.push_back(want);
   endfunction

   function void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         fail_count++;
      end
   endfunction

   function void check_response(rsp_type got);
      rsp_type want;
      if (pending.size() == 0) begin
         $display("%0t: response with nothing expected, actual %p", $time, got);
         fail_count++;
         return;
      end
      want = pending.pop_front();
      check_field("chip_select_n", want.chip_select_n, got.chip_select_n);
      check_field("mosi", want.mosi, got.mosi);
      check_field("clock_pulse", want.clock_pulse, got.clock_pulse);
      check_field("busy_res", want.busy_res, got.busy_res);
      check_field("done_res", want.done_res, got.done_res);
      check_field("read_byte", want.read_byte, got.read_byte);
   endfunction
endclass

module tb_spi_register_access_master;

   // opcode 3 has no meaning in the block and acts as a plain tick
   localparam logic [OPCODE_W-1:0] OP_SPARE = 2'd3;

   // receiver stall patterns, each held in turn while stall_count[9:8] selects it
   localparam logic [1:0] STALL_NONE   = 2'd0;
   localparam logic [1:0] STALL_RANDOM = 2'd1;
   localparam logic [1:0] STALL_SPARSE = 2'd2;
   localparam logic [1:0] STALL_LONG   = 2'd3;

   localparam int REQUEST_TARGET = 1200;

   logic clock = 1'b0;
   logic reset;

   spra_req_if req_bus ();
   spra_rsp_if rsp_bus ();

   spi_register_access_master dut (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus)
   );

   spi_access_scoreboard sb = new();

   int          requests_sent = 0;
   int          burst_left    = 0;
   logic [9:0]  stall_count   = '0;

   always #6 clock = ~clock;

   // receiver side: rotate through stall patterns so stalls hit every bit period
   always @(posedge clock) begin
      stall_count <= stall_count + 1'b1;
      case (stall_count[9:8])
         STALL_NONE: begin
            rsp_bus.ready <= 1'b1;
         end
         STALL_RANDOM: begin
            rsp_bus.ready <= ($urandom_range(0, 3) != 0);
         end
         STALL_SPARSE: begin
            // ready only when the low three bits of stall_count are zero
            rsp_bus.ready <= (stall_count[2:0] == 3'd0);
         end
         STALL_LONG: begin
            // stalls while stall_count[5:4] is zero, between open windows
            rsp_bus.ready <= (stall_count[5:4] != 2'b00);
         end
         default: begin
            rsp_bus.ready <= 1'b1;
         end
      endcase
   end

   // monitor: note accepted requests first, then check accepted responses
   always @(posedge clock) begin : monitor
      req_type seen_req;
      rsp_type seen_rsp;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            seen_req.opcode     = req_bus.opcode;
            seen_req.reg_addr   = req_bus.reg_addr;
            seen_req.write_data = req_bus.write_data;
            seen_req.miso       = req_bus.miso;
            sb.note_request(seen_req);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            seen_rsp.chip_select_n = rsp_bus.chip_select_n;
            seen_rsp.mosi          = rsp_bus.mosi;
            seen_rsp.clock_pulse   = rsp_bus.clock_pulse;
            seen_rsp.busy_res      = rsp_bus.busy_res;
            seen_rsp.done_res      = rsp_bus.done_res;
            seen_rsp.read_byte     = rsp_bus.read_byte;
            sb.check_response(seen_rsp);
         end
      end
   end

   // drive one bit period and wait for the request to be taken
   task automatic issue(input logic [OPCODE_W-1:0] op, input logic [ADDR_W-1:0] addr,
                        input logic [DATA_W-1:0] data, input logic miso_bit);
      int gap;
      if (burst_left == 0) begin
         // sender pause between bursts; occasionally a long unbroken burst
         gap = $urandom_range(1, 6);
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 200)
                                                  : $urandom_range(1, 40);
      end
      req_bus.valid      <= 1'b1;
      req_bus.opcode     <= op;
      req_bus.reg_addr   <= addr;
      req_bus.write_data <= data;
      req_bus.miso       <= miso_bit;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      burst_left--;
      requests_sent++;
   endtask

   function automatic logic [OPCODE_W-1:0] pick_noise_op();
      case ($urandom_range(0, 2))
         0:       return OP_WRITE;
         1:       return OP_READ;
         default: return OP_SPARE;
      endcase
   endfunction

   // one well-formed access with random content, stray opcodes mixed in
   task automatic random_access();
      logic [OPCODE_W-1:0] op;
      int                  miso_style;
      int                  tail;
      logic                miso_bit;
      op         = $urandom_range(0, 1) ? OP_WRITE : OP_READ;
      miso_style = $urandom_range(0, 3);
      issue(op, ADDR_W'($urandom_range(0, 63)), DATA_W'($urandom_range(0, 255)),
            1'($urandom_range(0, 1)));
      for (int i = 1; i < FRAME_W; i++) begin
         // constant miso now and then so read bytes of all zeros and all ones show up
         case (miso_style)
            0:       miso_bit = 1'b0;
            1:       miso_bit = 1'b1;
            default: miso_bit = 1'($urandom_range(0, 1));
         endcase
         // starts while busy must be taken as plain ticks
         op = ($urandom_range(0, 7) == 0) ? pick_noise_op() : OP_TICK;
         issue(op, ADDR_W'($urandom_range(0, 63)), DATA_W'($urandom_range(0, 255)),
               miso_bit);
      end
      // idle periods between accesses, often none so starts come back to back
      tail = $urandom_range(0, 1) ? 0 : $urandom_range(1, 3);
      repeat (tail)
         issue($urandom_range(0, 1) ? OP_TICK : OP_SPARE, ADDR_W'($urandom_range(0, 63)),
               DATA_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
   endtask

   initial begin
      req_bus.valid      <= 1'b0;
      req_bus.opcode     <= OP_TICK;
      req_bus.reg_addr   <= '0;
      req_bus.write_data <= '0;
      req_bus.miso       <= 1'b0;
      reset              <= 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // idle tick with all fields low, unused opcode with all fields high
      issue(OP_TICK, 6'h00, 8'h00, 1'b0);
      issue(OP_SPARE, 6'h3f, 8'hff, 1'b1);

      // write to the top address with an all-ones byte, miso ignored throughout,
      // starts and the unused opcode arriving while busy
      issue(OP_WRITE, 6'h3f, 8'hff, 1'b1);
      for (int i = 1; i < FRAME_W; i++) begin
         case (i)
            3:       issue(OP_READ, 6'h00, 8'h00, 1'b0);
            5:       issue(OP_SPARE, 6'h15, 8'h5a, 1'b1);
            7:       issue(OP_WRITE, 6'h2a, 8'h00, 1'b1);
            default: issue(OP_TICK, 6'h00, 8'h00, i[0]);
         endcase
      end

      // read from address zero, first periods only; the random part runs on into it
      issue(OP_READ, 6'h00, 8'h00, 1'b1);
      repeat (5) issue(OP_TICK, 6'h00, 8'h00, 1'b1);

      while (requests_sent < REQUEST_TARGET) random_access();

      req_bus.valid <= 1'b0;
      // let the monitor note the last request before draining
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
      // the response is registered; the wait below catches any unexpected response
      repeat (4) @(posedge clock);

      if (sb.fail_count == 0 && sb.pending.size() == 0) begin
         $display("tb_spi_register_access_master OK");
      end else begin
         $display("tb_spi_register_access_master NOT OK");
      end
      $finish;
   end

   // hang guard, far beyond the slowest correct run
   initial begin
      #5_000_000;
      $display("tb_spi_register_access_master NOT OK");
      $finish;
   end

endmodule

@@ spi_register_access_master.f @@
rtl/core/spra_pkg.sv
rtl/core/spra_req_if.sv
rtl/core/spra_rsp_if.sv
rtl/core/spra_engine.sv
rtl/core/spi_register_access_master.sv
tb/tb_spi_register_access_master.sv
